### hdl/conv2d_pad_stride_bias_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conv2d core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONV2D_PAD_STRIDE_BIAS_CORE_MACROS_SVH
`define CONV2D_PAD_STRIDE_BIAS_CORE_MACROS_SVH

// Check a condition at every clock edge.
`define CPSB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CPSB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/cpsb_pkg.sv
// ----------------------------------------------------------------------------
// cpsb_pkg
// Word types, mode codes and register indexes of the conv2d core.
// ----------------------------------------------------------------------------
package cpsb_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_CH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_H    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_W    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KSIZE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN = 4'd7;

  localparam logic [1:0] MODE_WGT   = 2'd0;
  localparam logic [1:0] MODE_BIAS  = 2'd1;
  localparam logic [1:0] MODE_IMG   = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // signed image coordinate and product of output position and stride
  localparam int CRD_W = 11;
  localparam int RS_W  = 9;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         out_chan;
    logic [3:0]         in_chan;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] sum_value;
    logic               bad_query;
  } out_word_t;

endpackage

### hdl/cpsb_ram.sv
// ----------------------------------------------------------------------------
// cpsb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/conv2d_pad_stride_bias_core.sv
// Loads: weight and sample words form their address in the shared multiply-add before the write;
// a bias word is written directly. A query runs setup, walks in_channels*k*k taps (k the kernel
// side) and drains; a bad query or one with no in-channels skips the walk. One word in flight;
// the tap walk through the single multiply-accumulate unit (one tap per cycle) sets the query time.
// Reset sets control and configuration to defaults; the three stores are undefined until written.
// ----------------------------------------------------------------------------
// conv2d_pad_stride_bias_core
// One output element of a zero-padded, strided 2D convolution with optional
// per-output-channel bias, computed by a sequencer over a single MAC unit and a shared multiply-add.
// ----------------------------------------------------------------------------
`include "conv2d_pad_stride_bias_core_macros.svh"

module conv2d_pad_stride_bias_core #(
  parameter int MAX_IN_CH  = 16,
  parameter int MAX_OUT_CH = 16,
  parameter int MAX_DIM    = 64,
  parameter int MAX_KERNEL = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cpsb_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cpsb_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cpsb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import cpsb_pkg::*;

  localparam int IMG_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
  localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int IAW = $clog2(IMG_DEPTH);
  localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int DD  = MAX_DIM * MAX_DIM;
  localparam int KK  = MAX_KERNEL * MAX_KERNEL;
  localparam int UW  = $clog2((MAX_IN_CH * MAX_DIM + 512) * MAX_DIM + WGT_DEPTH) + 2;
  localparam int MW  = $clog2(MAX_IN_CH + MAX_DIM + MAX_KERNEL + 8);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration
  logic [4:0] cfg_in_ch_q, cfg_out_ch_q;
  logic [6:0] cfg_in_h_q, cfg_in_w_q;
  logic [2:0] cfg_ksize_q, cfg_stride_q;
  logic [1:0] cfg_pad_q;
  logic       cfg_bias_en_q;

  // effective sizes
  logic [4:0] nic_c, noc_c;
  logic [6:0] h_c, w_c;
  logic [2:0] k0_c, k_c, s_c;

  // sequencer
  logic [2:0] st_q, step_q;
  logic [4:0] c_q;
  logic [2:0] kr_q, kc_q;
  logic       kc_last_c, kr_last_c, c_last_c;
  logic       tap_v1_q, tap_v2_q, tap_ok_c;
  logic       out_valid_q, out_free_c;
  logic       load_ok_c;
  logic [2:0] load_last_c;
  logic       bad_c;
  logic [9:0] ph_c, pw_c;

  // datapath
  in_word_t                item_q;
  logic signed [UW-1:0]    mul_a, mul_x, u_d, u_q;
  logic [MW-1:0]           mul_m;
  logic [RS_W-1:0]         rs_q;
  logic signed [CRD_W-1:0] ir0_c, ic0_c, ir0_q, ic0_q, ir_q, icol_q;
  logic signed [UW-1:0]    ir0md_q, ichb_q, rowaddr_q, img_sum_c;
  logic [WAW-1:0]          wch_q, wrow_q;
  logic signed [31:0]      prod_q;
  logic signed [47:0]      acc_q, out_sum_q;
  logic                    bad_q, out_bad_q;

  // stores
  logic           img_we, wgt_we, bias_we;
  logic [IAW-1:0] img_raddr;
  logic [WAW-1:0] wgt_raddr;
  logic [15:0]    img_rd, wgt_rd;
  logic [31:0]    bias_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_ch_q   <= 5'd1;
      cfg_out_ch_q  <= 5'd1;
      cfg_in_h_q    <= 7'd1;
      cfg_in_w_q    <= 7'd1;
      cfg_ksize_q   <= 3'd1;
      cfg_pad_q     <= 2'd0;
      cfg_stride_q  <= 3'd1;
      cfg_bias_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_CH:   cfg_in_ch_q   <= cfg_data_i[4:0];
        CFG_OUT_CH:  cfg_out_ch_q  <= cfg_data_i[4:0];
        CFG_IN_H:    cfg_in_h_q    <= cfg_data_i[6:0];
        CFG_IN_W:    cfg_in_w_q    <= cfg_data_i[6:0];
        CFG_KSIZE:   cfg_ksize_q   <= cfg_data_i[2:0];
        CFG_PAD:     cfg_pad_q     <= cfg_data_i[1:0];
        CFG_STRIDE:  cfg_stride_q  <= cfg_data_i[2:0];
        CFG_BIAS_EN: cfg_bias_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nic_c = (int'(cfg_in_ch_q) > MAX_IN_CH) ? 5'(MAX_IN_CH) : cfg_in_ch_q;
    noc_c = (int'(cfg_out_ch_q) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : cfg_out_ch_q;
    h_c   = (int'(cfg_in_h_q) > MAX_DIM) ? 7'(MAX_DIM) : cfg_in_h_q;
    w_c   = (int'(cfg_in_w_q) > MAX_DIM) ? 7'(MAX_DIM) : cfg_in_w_q;
    k0_c  = (cfg_ksize_q == 3'd0) ? 3'd1 : cfg_ksize_q;
    k_c   = (int'(k0_c) > MAX_KERNEL) ? 3'(MAX_KERNEL) : k0_c;
    s_c   = (cfg_stride_q == 3'd0) ? 3'd1 : cfg_stride_q;
    ph_c  = 10'(h_c) + 10'({cfg_pad_q, 1'b0});
    pw_c  = 10'(w_c) + 10'({cfg_pad_q, 1'b0});
  end

  // load checks
  always_comb begin
    case (item_q.mode)
      MODE_WGT: begin
        load_ok_c = (int'(item_q.out_chan) < MAX_OUT_CH) && (int'(item_q.in_chan) < MAX_IN_CH)
                 && (int'(item_q.row) < MAX_KERNEL) && (int'(item_q.col) < MAX_KERNEL);
        load_last_c = 3'd3;
      end
      MODE_IMG: begin
        load_ok_c = (int'(item_q.in_chan) < MAX_IN_CH) && (int'(item_q.row) < MAX_DIM)
                 && (int'(item_q.col) < MAX_DIM);
        load_last_c = 3'd2;
      end
      MODE_BIAS: begin
        load_ok_c   = int'(item_q.out_chan) < MAX_OUT_CH;
        load_last_c = 3'd0;
      end
      default: begin
        load_ok_c   = 1'b0;
        load_last_c = 3'd0;
      end
    endcase
  end

  assign ir0_c = $signed(CRD_W'(rs_q) - CRD_W'(cfg_pad_q));
  assign ic0_c = $signed(CRD_W'(u_q[RS_W-1:0]) - CRD_W'(cfg_pad_q));
  assign bad_c = ({1'b0, item_q.out_chan} >= noc_c)
              || ((10'(rs_q) + 10'(k_c)) > ph_c)
              || ((10'(u_q[RS_W-1:0]) + 10'(k_c)) > pw_c);

  // shared multiply-add for addresses and output position scaling
  always_comb begin
    mul_a = '0;
    mul_m = '0;
    mul_x = '0;
    case (st_q)
      ST_LOAD: begin
        if (item_q.mode == MODE_WGT) begin
          if (step_q == 3'd0) begin
            mul_a = UW'(item_q.out_chan);
            mul_m = MW'(MAX_IN_CH);
            mul_x = UW'(item_q.in_chan);
          end else begin
            mul_a = u_q;
            mul_m = MW'(MAX_KERNEL);
            mul_x = (step_q == 3'd1) ? UW'(item_q.row) : UW'(item_q.col);
          end
        end else begin
          mul_a = (step_q == 3'd0) ? UW'(item_q.in_chan) : u_q;
          mul_m = MW'(MAX_DIM);
          mul_x = (step_q == 3'd0) ? UW'(item_q.row) : UW'(item_q.col);
        end
      end
      ST_SETUP: begin
        case (step_q)
          3'd0: begin
            mul_a = UW'(item_q.row);
            mul_m = MW'(s_c);
          end
          3'd1: begin
            mul_a = UW'(item_q.col);
            mul_m = MW'(s_c);
          end
          3'd2: begin
            mul_a = UW'(ir0_c);
            mul_m = MW'(MAX_DIM);
          end
          3'd3: begin
            mul_a = UW'(item_q.out_chan);
            mul_m = MW'(MAX_IN_CH);
          end
          default: begin
            mul_a = u_q;
            mul_m = MW'(MAX_KERNEL);
          end
        endcase
      end
      default: ;
    endcase
  end

  assign u_d = mul_a * $signed(UW'(mul_m)) + mul_x;

  // tap walk
  assign kc_last_c  = (kc_q == k_c - 3'd1);
  assign kr_last_c  = (kr_q == k_c - 3'd1);
  assign c_last_c   = (c_q == nic_c - 5'd1);
  assign tap_ok_c   = !ir_q[CRD_W-1] && (ir_q < $signed(CRD_W'(h_c)))
                   && !icol_q[CRD_W-1] && (icol_q < $signed(CRD_W'(w_c)));
  assign img_sum_c  = rowaddr_q + UW'(icol_q);
  assign img_raddr  = IAW'(img_sum_c);
  assign wgt_raddr  = wrow_q + WAW'(kc_q);
  assign out_free_c = !out_valid_q || out_ready_i;

  assign wgt_we  = (st_q == ST_LOAD) && load_ok_c && (item_q.mode == MODE_WGT)
                && (step_q == load_last_c);
  assign img_we  = (st_q == ST_LOAD) && load_ok_c && (item_q.mode == MODE_IMG)
                && (step_q == load_last_c);
  assign bias_we = (st_q == ST_LOAD) && load_ok_c && (item_q.mode == MODE_BIAS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      c_q         <= '0;
      kr_q        <= '0;
      kc_q        <= '0;
      tap_v1_q    <= 1'b0;
      tap_v2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tap_v1_q <= (st_q == ST_RUN) && tap_ok_c;
      tap_v2_q <= tap_v1_q;
      if (st_q == ST_DONE && out_free_c) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q <= '0;
            st_q   <= (in_word_i.mode == MODE_QUERY) ? ST_SETUP : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!load_ok_c || step_q == load_last_c) begin
            st_q <= ST_IDLE;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_SETUP: begin
          if (step_q == 3'd2 && bad_c) begin
            st_q <= ST_DONE;
          end else if (step_q == 3'd6) begin
            step_q <= '0;
            c_q    <= '0;
            kr_q   <= '0;
            kc_q   <= '0;
            st_q   <= (nic_c == 5'd0) ? ST_DONE : ST_RUN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_RUN: begin
          if (kc_last_c) begin
            kc_q <= '0;
            if (kr_last_c) begin
              kr_q <= '0;
              if (c_last_c) begin
                step_q <= '0;
                st_q   <= ST_DRAIN;
              end else begin
                c_q <= c_q + 5'd1;
              end
            end else begin
              kr_q <= kr_q + 3'd1;
            end
          end else begin
            kc_q <= kc_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (step_q == 3'd1) begin
            st_q <= ST_DONE;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_DONE: begin
          if (out_free_c) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_word_i;
    end
    if (st_q == ST_LOAD || st_q == ST_SETUP) begin
      u_q <= u_d;
    end
    if (st_q == ST_SETUP && step_q == 3'd1) begin
      rs_q <= u_q[RS_W-1:0];
    end
    if (st_q == ST_SETUP && step_q == 3'd2) begin
      ir0_q <= ir0_c;
      ic0_q <= ic0_c;
      bad_q <= bad_c;
    end
    if (st_q == ST_SETUP && step_q == 3'd3) begin
      ir0md_q <= u_q;
    end
    if (st_q == ST_SETUP && step_q == 3'd6) begin
      wch_q     <= WAW'(u_q);
      wrow_q    <= WAW'(u_q);
      ichb_q    <= '0;
      rowaddr_q <= ir0md_q;
      ir_q      <= ir0_q;
      icol_q    <= ic0_q;
    end
    if (st_q == ST_RUN) begin
      if (kc_last_c) begin
        icol_q <= ic0_q;
        if (kr_last_c) begin
          ir_q      <= ir0_q;
          wch_q     <= wch_q + WAW'(KK);
          wrow_q    <= wch_q + WAW'(KK);
          ichb_q    <= ichb_q + UW'(DD);
          rowaddr_q <= ichb_q + UW'(DD) + ir0md_q;
        end else begin
          ir_q      <= ir_q + CRD_W'(1);
          wrow_q    <= wrow_q + WAW'(MAX_KERNEL);
          rowaddr_q <= rowaddr_q + UW'(MAX_DIM);
        end
      end else begin
        icol_q <= icol_q + CRD_W'(1);
      end
    end
    prod_q <= $signed(img_rd) * $signed(wgt_rd);
    if (st_q == ST_SETUP && step_q == 3'd6) begin
      acc_q <= cfg_bias_en_q ? 48'($signed(bias_rd)) : '0;
    end else if (tap_v2_q) begin
      acc_q <= acc_q + 48'(prod_q);
    end
    if (st_q == ST_DONE && out_free_c) begin
      out_sum_q <= bad_q ? '0 : acc_q;
      out_bad_q <= bad_q;
    end
  end

  cpsb_ram #(.WIDTH(16), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (IAW'(u_q)),
    .wdata_i (item_q.value[15:0]),
    .raddr_i (img_raddr),
    .rdata_o (img_rd)
  );

  cpsb_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (WAW'(u_q)),
    .wdata_i (item_q.value[15:0]),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rd)
  );

  cpsb_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .waddr_i (OCW'(item_q.out_chan)),
    .wdata_i (item_q.value),
    .raddr_i (OCW'(item_q.out_chan)),
    .rdata_o (bias_rd)
  );

  assign in_ready_o           = (st_q == ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign out_word_o.sum_value = out_sum_q;
  assign out_word_o.bad_query = out_bad_q;

  `CPSB_ASSERT(a_one_store_write, $onehot0({img_we, wgt_we, bias_we}), "two stores written")
  `CPSB_ASSERT_IMP(a_tap_from_run, tap_v1_q, $past(st_q) == ST_RUN, "tap issued outside walk")
  `CPSB_ASSERT_IMP(a_done_drained, st_q == ST_DONE, !tap_v1_q && !tap_v2_q, "result before drain")
  `CPSB_ASSERT_IMP(a_result_src, $rose(out_valid_o), $past(st_q) == ST_DONE, "stray result word")

endmodule
